// File: design/bcsa_pkg.sv
// Shared types and constants for the set-associative block tag store.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package bcsa_pkg;

    localparam int DEF_NUM_SETS   = 2048;
    localparam int DEF_NUM_WAYS   = 4;
    localparam int DEF_HASH_SHIFT = 13;
    localparam int QUEUE_DEPTH    = 2;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 16;
    localparam int RUNS_W  = 16;
    localparam int THR_W   = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd16;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INVAL  = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic              sor;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
        logic [RUNS_W-1:0]  runs;
    } way_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_CLEAR,
        ST_FLUSH_OUT
    } back_state_t;

endpackage

// File: design/block_cache_set_assoc_lru.sv
// Top level of the set-associative tag store for translated code blocks.
// Depends on bcsa_pkg, bcsa_front, bcsa_queue and bcsa_back.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   tdata: block_address; tuser: op, start_of_run
//  m_        out        m_tvalid/m_tready   tdata: hit .. compile_now, one per transfer
//  cfg_      in         cfg_wr_en           compile_threshold, no read-back
//
// In the back end a lookup or invalidate first reads the set row and the successor
// link when it is popped (ST_IDLE), then updates the row (ST_EXEC); a lookup that
// both allocates and records a link goes on to ST_LINK for the second successor-memory write.
// A flush sweeps the set memory at one row per cycle, as does the clearing pass that
// follows reset; s_tready stays low during either sweep.
// The two-entry queue lets the front accept transfers while the back end works,
// and the result register holds a result until m_tready takes it.

module block_cache_set_assoc_lru
    import bcsa_pkg::*;
#(
    parameter int NUM_SETS   = DEF_NUM_SETS,   // power of two
    parameter int NUM_WAYS   = DEF_NUM_WAYS,
    parameter int HASH_SHIFT = DEF_HASH_SHIFT,
    localparam int SET_W     = $clog2(NUM_SETS),
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
    localparam int OUT_BITS  = 4 + SET_W + WAY_W + ADDR_W,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ADDR_W-1:0]  s_tdata,    // block_address
    input  logic [2:0]         s_tuser,    // op[1:0], start_of_run[2]
    output logic               m_tvalid,
    input  logic               m_tready,
    // hit, linked, set_index, way_index, evicted, evicted_address, compile_now, zero fill
    output logic [OUT_W-1:0]   m_tdata,
    input  logic               cfg_wr_en,
    input  logic [THR_W-1:0]   cfg_wr_data
);

    localparam int QDATA_W = $bits(item_t) + SET_W;

    logic [THR_W-1:0]   thr_reg;
    back_status_t       status;
    logic               push, pop, q_empty, q_full;
    item_t              push_item, head_item;
    logic [SET_W-1:0]   push_set, head_set;
    logic [QDATA_W-1:0] head_data;

    logic               o_hit, o_linked, o_ev, o_comp;
    logic [SET_W-1:0]   o_set;
    logic [WAY_W-1:0]   o_way;
    logic [ADDR_W-1:0]  o_ev_addr;

    // Threshold register; software must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    bcsa_front #(
        .NUM_SETS   (NUM_SETS),
        .HASH_SHIFT (HASH_SHIFT)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (q_full),
        .status     (status),
        .push       (push),
        .push_item  (push_item),
        .push_set   (push_set)
    );

    bcsa_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_item, push_set}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_item = item_t'(head_data[QDATA_W-1:SET_W]);
    assign head_set  = head_data[SET_W-1:0];

    bcsa_back #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .head_item   (head_item),
        .head_set    (head_set),
        .pop         (pop),
        .threshold   (thr_reg),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_hit     (o_hit),
        .out_linked  (o_linked),
        .out_set     (o_set),
        .out_way     (o_way),
        .out_evicted (o_ev),
        .out_ev_addr (o_ev_addr),
        .out_compile (o_comp),
        .status      (status)
    );

    assign m_tdata = OUT_W'({o_comp, o_ev_addr, o_ev, o_way, o_set, o_linked, o_hit});

    // No transfer may enter while the set memory is being swept.
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_tready)
        else $error("input accepted during memory sweep");

    // A replaced entry only comes with a miss.
    a_evict_is_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_ev) |-> !o_hit)
        else $error("eviction reported on a hit");

    // A linked result is always a hit.
    a_linked_is_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_linked) |-> o_hit)
        else $error("linked without hit");

    // The evicted address is zero unless an entry was replaced.
    a_ev_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !o_ev) |-> (o_ev_addr == '0))
        else $error("evicted address without eviction");

endmodule

// File: design/bcsa_front.sv
// Front end: accepts input transfers, decodes the operation and hashes the set.
// Depends on bcsa_pkg; pushes classified work into bcsa_queue.
`timescale 1ns / 1ps

module bcsa_front
    import bcsa_pkg::*;
#(
    parameter int NUM_SETS   = DEF_NUM_SETS,
    parameter int HASH_SHIFT = DEF_HASH_SHIFT,
    localparam int SET_W     = $clog2(NUM_SETS)
) (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ADDR_W-1:0]  s_tdata,   // block_address
    input  logic [2:0]         s_tuser,   // op[1:0], start_of_run[2]
    input  logic               queue_full,
    input  back_status_t       status,
    output logic               push,
    output item_t              push_item,
    output logic [SET_W-1:0]   push_set
);

    assign s_tready       = !queue_full && !status.clearing;
    assign push           = s_tvalid && s_tready;
    assign push_item.op   = op_t'(s_tuser[1:0]);
    assign push_item.addr = s_tdata;
    assign push_item.sor  = s_tuser[2];
    // The set count is a power of two, so the modulo is a truncation.
    assign push_set = SET_W'((s_tdata >> 1) ^ (s_tdata >> HASH_SHIFT));

endmodule

// File: design/bcsa_queue.sv
// Short register queue between the front and back ends.
// Depends on bcsa_pkg for its default depth.
`timescale 1ns / 1ps

module bcsa_queue
    import bcsa_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              empty,
    output logic              full
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign head_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/bcsa_back.sv
// Back end: set memory, successor links, replacement and the result register.
// Depends on bcsa_pkg; pops work from bcsa_queue.
`timescale 1ns / 1ps

module bcsa_back
    import bcsa_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    localparam int SET_W   = $clog2(NUM_SETS),
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
    localparam int ENT_W   = SET_W + WAY_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               queue_empty,
    input  item_t              head_item,
    input  logic [SET_W-1:0]   head_set,
    output logic               pop,
    input  logic [THR_W-1:0]   threshold,
    input  logic               m_tready,
    output logic               out_valid,
    output logic               out_hit,
    output logic               out_linked,
    output logic [SET_W-1:0]   out_set,
    output logic [WAY_W-1:0]   out_way,
    output logic               out_evicted,
    output logic [ADDR_W-1:0]  out_ev_addr,
    output logic               out_compile,
    output back_status_t       status
);

    // Link words are {valid, set, way}.
    way_t [NUM_WAYS-1:0] row_mem [NUM_SETS];
    logic [ENT_W:0]      succ_mem [1 << ENT_W];

    back_state_t         state_reg, state_next;
    item_t               cur_reg;
    logic [SET_W-1:0]    set_reg;
    logic [ENT_W:0]      prev_reg, prev_next, prev_eff_reg, prev_eff;
    logic [ENT_W-1:0]    link_reg;
    logic [STAMP_W-1:0]  clock_reg;
    logic [SET_W-1:0]    clr_reg;
    way_t [NUM_WAYS-1:0] row_rd_reg;
    logic [ENT_W:0]      succ_rd_reg;

    logic                out_valid_reg, hit_reg, linked_reg, ev_reg, comp_reg;
    logic [SET_W-1:0]    oset_reg;
    logic [WAY_W-1:0]    oway_reg;
    logic [ADDR_W-1:0]   ev_addr_reg;

    logic                out_free, clr_last, out_load;
    logic                row_we, succ_we;
    logic [SET_W-1:0]    row_waddr;
    way_t [NUM_WAYS-1:0] row_wdata;
    logic [ENT_W-1:0]    succ_waddr;
    logic [ENT_W:0]      succ_wdata;

    logic [NUM_WAYS-1:0] match;
    logic                found, lk, have_empty, alloc, need_link, comp, runs_full;
    logic [WAY_W-1:0]    hit_w, victim, chosen;
    logic [STAMP_W-1:0]  clock_inc;
    logic [RUNS_W-1:0]   runs_inc;
    way_t                nw;
    way_t [NUM_WAYS-1:0] row_upd;

    assign out_free    = !out_valid_reg || m_tready;
    assign clr_last    = (clr_reg == SET_W'(NUM_SETS - 1));
    assign prev_eff    = (head_item.op == OP_LOOKUP && head_item.sor) ? '0 : prev_reg;
    assign clock_inc   = clock_reg + 1'b1;
    assign status.clearing = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);

    // Hit, link and replacement selection over the registered row.
    always_comb begin
        found      = 1'b0;
        lk         = 1'b0;
        have_empty = 1'b0;
        hit_w      = '0;
        victim     = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = row_rd_reg[w].valid && (row_rd_reg[w].tag == cur_reg.addr);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                found = 1'b1;
                hit_w = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!row_rd_reg[w].valid) begin
                victim     = WAY_W'(w);
                have_empty = 1'b1;
            end else if (!have_empty && row_rd_reg[w].stamp < row_rd_reg[victim].stamp) begin
                victim = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (prev_eff_reg[ENT_W] && succ_rd_reg[ENT_W]
                && succ_rd_reg[ENT_W-1:WAY_W] == set_reg
                && succ_rd_reg[WAY_W-1:0] == WAY_W'(w) && match[w]) begin
                lk = 1'b1;
            end
        end
        chosen    = lk ? succ_rd_reg[WAY_W-1:0] : (found ? hit_w : victim);
        alloc     = !lk && !found;
        need_link = prev_eff_reg[ENT_W] && !lk;

        nw = row_rd_reg[chosen];
        if (alloc) begin
            nw.valid = 1'b1;
            nw.tag   = cur_reg.addr;
            nw.runs  = '0;
        end
        nw.stamp  = clock_inc;
        runs_full = (nw.runs == '1);
        runs_inc  = nw.runs + 1'b1;
        comp      = !runs_full && (runs_inc == threshold);
        if (!runs_full) begin
            nw.runs = runs_inc;
        end

        row_upd = row_rd_reg;
        if (cur_reg.op == OP_LOOKUP) begin
            row_upd[chosen] = nw;
        end else if (found) begin
            row_upd[hit_w].valid = 1'b0;
            row_upd[hit_w].runs  = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:      if (clr_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (!queue_empty) begin
                    state_next = (head_item.op == OP_FLUSH) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = (cur_reg.op == OP_LOOKUP && alloc && need_link)
                                 ? ST_LINK : ST_IDLE;
                end
            end
            ST_LINK:      state_next = ST_IDLE;
            ST_CLEAR:     if (clr_last) state_next = ST_FLUSH_OUT;
            ST_FLUSH_OUT: if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_INIT;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        out_load   = 1'b0;
        row_we     = 1'b0;
        row_waddr  = set_reg;
        row_wdata  = row_upd;
        succ_we    = 1'b0;
        succ_waddr = prev_eff_reg[ENT_W-1:0];
        succ_wdata = {1'b1, link_reg};
        prev_next  = prev_reg;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = clr_reg;
                row_wdata = '0;
                if (state_reg == ST_CLEAR) begin
                    prev_next = '0;
                end
            end
            ST_IDLE: pop = !queue_empty;
            ST_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    row_we   = (cur_reg.op == OP_LOOKUP) || (cur_reg.op == OP_INVAL && found);
                    if (cur_reg.op == OP_LOOKUP) begin
                        prev_next = {1'b1, set_reg, chosen};
                        if (alloc) begin
                            succ_we    = 1'b1;
                            succ_waddr = {set_reg, chosen};
                            succ_wdata = '0;
                        end else if (need_link) begin
                            succ_we    = 1'b1;
                            succ_wdata = {1'b1, set_reg, chosen};
                        end
                    end
                end
            end
            ST_LINK:      succ_we = 1'b1;
            ST_FLUSH_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // The row and the link are captured when the item is popped and then held
    // while the result register waits.
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (pop) begin
            row_rd_reg <= row_mem[head_set];
        end
        if (succ_we) begin
            succ_mem[succ_waddr] <= succ_wdata;
        end
        if (pop) begin
            succ_rd_reg <= succ_mem[prev_eff[ENT_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            prev_reg      <= '0;
            clock_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
                clr_reg <= clr_last ? '0 : clr_reg + 1'b1;
            end
            if (state_reg == ST_EXEC && out_free && cur_reg.op == OP_LOOKUP) begin
                clock_reg <= clock_inc;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg      <= head_item;
            set_reg      <= head_set;
            prev_eff_reg <= prev_eff;
        end
        if (state_reg == ST_EXEC) begin
            link_reg <= {set_reg, chosen};
        end
        if (out_load) begin
            if (state_reg == ST_EXEC && cur_reg.op == OP_LOOKUP) begin
                hit_reg     <= !alloc;
                linked_reg  <= lk;
                oset_reg    <= set_reg;
                oway_reg    <= chosen;
                ev_reg      <= alloc && row_rd_reg[chosen].valid;
                ev_addr_reg <= (alloc && row_rd_reg[chosen].valid)
                               ? row_rd_reg[chosen].tag : '0;
                comp_reg    <= comp;
            end else if (state_reg == ST_EXEC && cur_reg.op == OP_INVAL) begin
                hit_reg     <= found;
                linked_reg  <= 1'b0;
                oset_reg    <= set_reg;
                oway_reg    <= found ? hit_w : '0;
                ev_reg      <= 1'b0;
                ev_addr_reg <= '0;
                comp_reg    <= 1'b0;
            end else begin
                hit_reg     <= 1'b0;
                linked_reg  <= 1'b0;
                oset_reg    <= '0;
                oway_reg    <= '0;
                ev_reg      <= 1'b0;
                ev_addr_reg <= '0;
                comp_reg    <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_hit     = hit_reg;
    assign out_linked  = linked_reg;
    assign out_set     = oset_reg;
    assign out_way     = oway_reg;
    assign out_evicted = ev_reg;
    assign out_ev_addr = ev_addr_reg;
    assign out_compile = comp_reg;

endmodule

// File: sim/bcsa_checker.sv
// Result checker for the block tag store: watches both streams, predicts each result.
// Depends on bcsa_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module bcsa_checker
    import bcsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [55:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    localparam int SETS = 2048;
    localparam int WAYS = 4;
    localparam int ENTRIES = SETS * WAYS;

    typedef struct packed {
        logic        hit;
        logic        linked;
        logic [10:0] set_index;
        logic [1:0]  way_index;
        logic        evicted;
        logic [31:0] evicted_address;
        logic        compile_now;
    } lookup_result_t;

    logic [31:0] tag_mem [ENTRIES];
    logic        valid_mem [ENTRIES];
    logic [15:0] stamp_mem [ENTRIES];
    logic [15:0] runs_mem [ENTRIES];
    logic [13:0] succ_mem [ENTRIES];
    logic [15:0] use_clock;
    logic [13:0] prev_block;
    logic [15:0] threshold;
    lookup_result_t expected_results[$];

    function automatic logic [10:0] set_hash(logic [31:0] a);
        return 11'((a >> 1) ^ (a >> 13));
    endfunction

    task automatic predict_block(op_t op, logic [31:0] a, logic sor);
        lookup_result_t r;
        int base, chosen, victim, t;
        logic found, via_link, have_empty;
        r = '0;
        base = int'(set_hash(a)) * WAYS;
        found = 0;
        via_link = 0;
        chosen = 0;
        if (op == OP_INVAL) begin
            r.set_index = set_hash(a);
            for (int w = 0; w < WAYS; w++) begin
                if (!found && valid_mem[base+w] && tag_mem[base+w] == a) begin
                    found = 1;
                    valid_mem[base+w] = 0;
                    runs_mem[base+w] = '0;
                    r.hit = 1;
                    r.way_index = 2'(w);
                end
            end
        end else if (op == OP_FLUSH) begin
            for (int e = 0; e < ENTRIES; e++) begin
                valid_mem[e] = 0;
                runs_mem[e] = '0;
                succ_mem[e] = '0;
            end
            prev_block = '0;
        end else if (op == OP_LOOKUP) begin
            r.set_index = set_hash(a);
            if (sor) prev_block = '0;
            if (prev_block != 0 && succ_mem[prev_block-1] != 0) begin
                t = succ_mem[prev_block-1] - 1;
                if (valid_mem[t] && tag_mem[t] == a) begin
                    found = 1;
                    via_link = 1;
                    chosen = t;
                end
            end
            if (!found) begin
                victim = base;
                have_empty = 0;
                for (int w = 0; w < WAYS; w++) begin
                    if (!found) begin
                        if (valid_mem[base+w] && tag_mem[base+w] == a) begin
                            found = 1;
                            chosen = base + w;
                        end else if (!valid_mem[base+w]) begin
                            victim = base + w;
                            have_empty = 1;
                        end else if (!have_empty && stamp_mem[base+w] < stamp_mem[victim]) begin
                            victim = base + w;
                        end
                    end
                end
                if (!found) begin
                    chosen = victim;
                    if (valid_mem[chosen]) begin
                        r.evicted = 1;
                        r.evicted_address = tag_mem[chosen];
                    end
                    tag_mem[chosen] = a;
                    valid_mem[chosen] = 1;
                    runs_mem[chosen] = '0;
                    succ_mem[chosen] = '0;
                end
            end
            if (prev_block != 0 && !via_link) succ_mem[prev_block-1] = 14'(chosen + 1);
            prev_block = 14'(chosen + 1);
            use_clock = use_clock + 16'd1;
            stamp_mem[chosen] = use_clock;
            if (runs_mem[chosen] != 16'hFFFF) begin
                runs_mem[chosen] = runs_mem[chosen] + 16'd1;
                r.compile_now = (runs_mem[chosen] == threshold);
            end
            r.hit = found;
            r.linked = via_link;
            r.way_index = 2'(chosen % WAYS);
        end
        expected_results.push_back(r);
    endtask

    // Unpack one result transfer from tdata, lowest field first.
    function automatic lookup_result_t unpack_result(logic [55:0] d);
        lookup_result_t r;
        r.hit = d[0];
        r.linked = d[1];
        r.set_index = d[12:2];
        r.way_index = d[14:13];
        r.evicted = d[15];
        r.evicted_address = d[47:16];
        r.compile_now = d[48];
        return r;
    endfunction

    initial begin
        for (int e = 0; e < ENTRIES; e++) begin
            tag_mem[e] = '0;
            valid_mem[e] = 0;
            stamp_mem[e] = '0;
            runs_mem[e] = '0;
            succ_mem[e] = '0;
        end
        use_clock = '0;
        prev_block = '0;
        threshold = THR_RESET;
        fail_count = 0;
        result_count = 0;
    end

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        lookup_result_t got, want;
        if (aresetn) begin
            if (cfg_wr_en) threshold = cfg_wr_data;
            if (s_tvalid && s_tready) predict_block(op_t'(s_tuser[1:0]), s_tdata, s_tuser[2]);
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.linked !== want.linked) begin
                        $error("linked: expected %0d actual %0d", want.linked, got.linked);
                        fail_count++;
                    end
                    if (got.set_index !== want.set_index) begin
                        $error("set_index: expected %0d actual %0d",
                               want.set_index, got.set_index);
                        fail_count++;
                    end
                    if (got.way_index !== want.way_index) begin
                        $error("way_index: expected %0d actual %0d",
                               want.way_index, got.way_index);
                        fail_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d actual %0d", want.evicted, got.evicted);
                        fail_count++;
                    end
                    if (got.evicted_address !== want.evicted_address) begin
                        $error("evicted_address: expected %h actual %h",
                               want.evicted_address, got.evicted_address);
                        fail_count++;
                    end
                    if (got.compile_now !== want.compile_now) begin
                        $error("compile_now: expected %0d actual %0d",
                               want.compile_now, got.compile_now);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_top.sv
// Stimulus and verdict for the set-associative block tag store.
// Depends on bcsa_pkg, bcsa_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import bcsa_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;   // op[1:0], start_of_run[2]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;        // hit, linked, set, way, evicted, evicted address, compile
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = '0;

    int fail_count, pending_count, result_count;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit calm = 0;          // no random idling while set
    logic [31:0] hot_blocks[16];   // small working set so hits and links recur

    always #4 aclk = ~aclk;

    block_cache_set_assoc_lru dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    bcsa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
    );

    // The receiver stalls at random, except during calm stretches, and holds off
    // entirely while hold_cycles counts down so that the block backs up.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("block_cache_set_assoc_lru: mismatch");
            $finish;
        end
    end

    // Offers one transfer, with random idle cycles ahead of it unless calm is set, and
    // waits until it is taken. s_tvalid stays high between back-to-back transfers.
    task automatic send_block(op_t op, logic [31:0] a, logic sor);
        if (!calm) begin
            while ($urandom_range(99) < 17) begin
                s_tvalid <= 0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1;
        s_tdata <= a;
        s_tuser <= {sor, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Lets the block drain before a threshold write.
    task automatic write_threshold(logic [15:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    // Builds addresses that all hash to one set: the hash is linear over XOR,
    // so adding a bit at position 13+k plus a bit at 1+k leaves the set alone.
    function automatic logic [31:0] same_set_addr(logic [31:0] seed, int n);
        logic [31:0] a;
        a = seed;
        for (int k = 0; k < 4; k++)
            if (n[k]) a = a ^ (32'h1 << (13 + k)) ^ (32'h1 << (1 + k));
        return a;
    endfunction

    task automatic random_phase(int count);
        int pick;
        logic [31:0] a;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                a = hot_blocks[$urandom_range(15)];
                send_block(OP_LOOKUP, a, $urandom_range(99) < 8);
            end else if (pick < 80) begin
                send_block(OP_LOOKUP, same_set_addr(32'h0000_4000, $urandom_range(15)),
                           1'($urandom_range(1)));
            end else if (pick < 88) begin
                send_block(OP_LOOKUP, $urandom, 1'($urandom_range(1)));
            end else if (pick < 95) begin
                a = ($urandom_range(1) == 1) ? hot_blocks[$urandom_range(15)] : $urandom;
                send_block(OP_INVAL, a, 1'($urandom_range(1)));
            end else if (pick < 97) begin
                send_block(OP_FLUSH, $urandom, 1'($urandom_range(1)));
            end else begin
                send_block(OP_NONE, $urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) hot_blocks[i] = $urandom & 32'hFFFF_FFFE;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part at the reset threshold: field extremes, an odd address,
        // each op, eviction in a full set, a linked hit, invalidate hit and miss.
        calm = 1;
        send_block(OP_LOOKUP, 32'h0000_0000, 1);
        send_block(OP_LOOKUP, 32'hFFFF_FFFF, 0);
        send_block(OP_LOOKUP, 32'h0000_0000, 0);
        send_block(OP_LOOKUP, 32'hFFFF_FFFF, 0);
        send_block(OP_LOOKUP, 32'h1234_5677, 0);
        for (int n = 0; n < 6; n++) send_block(OP_LOOKUP, same_set_addr(32'h0000_4000, n), 0);
        send_block(OP_INVAL, same_set_addr(32'h0000_4000, 5), 1);
        send_block(OP_INVAL, 32'hDEAD_BEEE, 0);
        send_block(OP_NONE, 32'hFFFF_FFFF, 1);
        send_block(OP_FLUSH, 32'h0, 0);
        send_block(OP_LOOKUP, 32'h0000_0000, 0);
        send_block(OP_INVAL, 32'h0000_0000, 0);
        calm = 0;

        // Threshold at one: every allocation compiles at once.
        write_threshold(16'd1);
        random_phase(250);

        // Pressure: the receiver holds off while the sender keeps offering.
        hold_cycles = 300;
        random_phase(40);

        write_threshold(16'hFFFF);
        calm = 1;
        random_phase(300);
        calm = 0;

        write_threshold(16'd3);
        random_phase(500);

        write_threshold(16'd16);
        random_phase(540);

        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered lookups, links, evictions, invalidates, flushes and the unused op");
        $display("over thresholds 1, 3, 16 and 65535; %0d results checked.", result_count);
        if (fail_count == 0) begin
            $display("block_cache_set_assoc_lru: match");
        end else begin
            $display("block_cache_set_assoc_lru: mismatch");
        end
        $finish;
    end

endmodule
